// ===== rtl/erm_pkg.sv =====
// Shared types and codes of the event ring with overflow marker.
package erm_pkg;

    // Field widths of one event.
    localparam int OP_W     = 8;
    localparam int COOKIE_W = 32;
    localparam int FLAGS_W  = 32;
    localparam int ID_W     = 64;
    localparam int SEQ_W    = 64;
    localparam int TOTAL_W  = 64;
    localparam int QUEUED_W = 11;

    // Stream and configuration widths.
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int S_DATA_W   = 200;
    localparam int M_DATA_W   = 408;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 11;
    localparam int CAP_W      = 11;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FLUSH = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MARKED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FLUSHED = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_TAP_ENABLED     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RING_CAPACITY   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_OVERFLOW_OPCODE = 2'd2;

    // Reset value of the ring capacity register.
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    // One ring slot.
    typedef struct packed {
        logic [SEQ_W-1:0]    seq;
        logic [ID_W-1:0]     object_id;
        logic [ID_W-1:0]     parent_id;
        logic [FLAGS_W-1:0]  flags;
        logic [COOKIE_W-1:0] cookie;
        logic [OP_W-1:0]     op;
    } entry_t;

endpackage

// ===== rtl/event_ring_with_overflow_marker.sv =====
// Event ring with overflow marker: top level with the slot memory and its control.
//
// Channels: requests arrive on the s_ stream (tuser carries the request kind, tdata the
// event), one result item per request leaves on the m_ stream (tuser carries the status,
// tdata the popped event and the fill level and totals). Registers are written through the
// cfg_ channel, which is always ready; write them only while the block is idle.
// Push, flush and a pop on an empty ring set the result register directly; a pop first
// passes through the S_POP state, because the slot memory has a registered read port; a
// push that first queues an overflow marker passes through the S_MARK state, because the
// slot memory has one write port and both the marker and the event are written.
// A new request is taken only in S_IDLE, so requests never overlap.
// The output register holds one result; a new request is accepted in the cycle that the
// waiting result is taken, so a stalled receiver stalls the request side after one item.
// Reset clears the indices, fill level, sequence number, armed marker and both totals, and
// sets the registers to enabled, full capacity and marker opcode zero. The slot memory is
// not cleared: a slot is only ever read after it has been written.
module event_ring_with_overflow_marker #(
    parameter int RING_DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Request stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: ev_op[7:0], ev_cookie[39:8], ev_flags[71:40], ev_parent_id[135:72],
    //        ev_object_id[199:136]
    input  logic [erm_pkg::S_DATA_W-1:0]      s_tdata,
    // tuser: req_type[1:0]
    input  logic [erm_pkg::REQ_W-1:0]         s_tuser,
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata: out_op[7:0], out_cookie[39:8], out_flags[71:40], out_parent_id[135:72],
    //        out_object_id[199:136], out_sequence[263:200], queued_now[274:264],
    //        events_total[338:275], drops_total[402:339], zero[407:403]
    output logic [erm_pkg::M_DATA_W-1:0]      m_tdata,
    // tuser: status[2:0]
    output logic [erm_pkg::STATUS_W-1:0]      m_tuser,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [erm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [erm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int CMP_W = (CNT_W > erm_pkg::CAP_W) ? CNT_W : erm_pkg::CAP_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(RING_DEPTH);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MARK = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [IDX_W-1:0]              wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]              rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]              fill_reg, fill_next;
    logic [erm_pkg::SEQ_W-1:0]     last_seq_reg, last_seq_next;
    logic                          marker_reg, marker_next;
    logic [erm_pkg::TOTAL_W-1:0]   ev_cnt_reg, ev_cnt_next;
    logic [erm_pkg::TOTAL_W-1:0]   drop_cnt_reg, drop_cnt_next;
    erm_pkg::entry_t               hold_reg, hold_next;
    logic                          out_valid_reg, out_valid_next;
    logic [erm_pkg::STATUS_W-1:0]  out_status_reg, out_status_next;
    logic                          out_popped_reg, out_popped_next;

    logic                          tap_en_reg;
    logic [erm_pkg::CAP_W-1:0]     cap_reg;
    logic [erm_pkg::OP_W-1:0]      ovf_op_reg;

    erm_pkg::entry_t               slot_mem [RING_DEPTH];
    erm_pkg::entry_t               rd_data_reg;
    erm_pkg::entry_t               wr_entry;
    erm_pkg::entry_t               in_entry;
    erm_pkg::entry_t               pop_entry;
    logic                          wr_en;
    logic                          rd_en;

    logic                          accept;
    logic [CMP_W-1:0]              cap_ext;
    logic [CMP_W-1:0]              cap_eff;
    logic [CMP_W-1:0]              fill_ext;
    logic                          ring_full;

    // Next slot index, wrapping at the capacity in use.
    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                 input logic [CMP_W-1:0] cap);
        logic [CMP_W-1:0] n;
        begin
            n = CMP_W'(idx) + CMP_W'(1);
            if (n >= cap || n >= DEPTH_C)
            begin
                advance = '0;
            end
            else
            begin
                advance = IDX_W'(n);
            end
        end
    endfunction

    // Capacity in use: an out-of-range setting falls back to the built depth.
    assign cap_ext   = CMP_W'(cap_reg);
    assign cap_eff   = (cap_reg == '0 || cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
    assign fill_ext  = CMP_W'(fill_reg);
    assign ring_full = (fill_ext >= cap_eff);

    // Event carried by the request item.
    always_comb
    begin
        in_entry           = '0;
        in_entry.op        = s_tdata[7:0];
        in_entry.cookie    = s_tdata[39:8];
        in_entry.flags     = s_tdata[71:40];
        in_entry.parent_id = s_tdata[135:72];
        in_entry.object_id = s_tdata[199:136];
    end

    // One request at a time, taken when the output register is empty or being emptied.
    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // Request sequencer: reads, updates and writes back the ring state.
    always_comb
    begin
        state_next      = state_reg;
        wr_idx_next     = wr_idx_reg;
        rd_idx_next     = rd_idx_reg;
        fill_next       = fill_reg;
        last_seq_next   = last_seq_reg;
        marker_next     = marker_reg;
        ev_cnt_next     = ev_cnt_reg;
        drop_cnt_next   = drop_cnt_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_popped_next = out_popped_reg;
        wr_en           = 1'b0;
        wr_entry        = in_entry;
        rd_en           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        erm_pkg::REQ_PUSH:
                        begin
                            if (!tap_en_reg)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = erm_pkg::ST_IGNORED;
                                out_popped_next = 1'b0;
                            end
                            else if (ring_full)
                            begin
                                drop_cnt_next   = drop_cnt_reg + 1'b1;
                                marker_next     = 1'b1;
                                out_valid_next  = 1'b1;
                                out_status_next = erm_pkg::ST_DROPPED;
                                out_popped_next = 1'b0;
                            end
                            else if (marker_reg)
                            begin
                                // Marker goes in first with the later number; the event
                                // waits in the hold register for the second write.
                                wr_en          = 1'b1;
                                wr_entry       = '0;
                                wr_entry.op    = ovf_op_reg;
                                wr_entry.seq   = last_seq_reg + 2'd2;
                                wr_idx_next    = advance(wr_idx_reg, cap_eff);
                                fill_next      = fill_reg + 1'b1;
                                last_seq_next  = last_seq_reg + 2'd2;
                                marker_next    = 1'b0;
                                ev_cnt_next    = ev_cnt_reg + 1'b1;
                                hold_next      = in_entry;
                                hold_next.seq  = last_seq_reg + 1'b1;
                                state_next     = S_MARK;
                            end
                            else
                            begin
                                wr_en           = 1'b1;
                                wr_entry.seq    = last_seq_reg + 1'b1;
                                wr_idx_next     = advance(wr_idx_reg, cap_eff);
                                fill_next       = fill_reg + 1'b1;
                                last_seq_next   = last_seq_reg + 1'b1;
                                ev_cnt_next     = ev_cnt_reg + 1'b1;
                                out_valid_next  = 1'b1;
                                out_status_next = erm_pkg::ST_OK;
                                out_popped_next = 1'b0;
                            end
                        end
                        erm_pkg::REQ_POP:
                        begin
                            if (fill_reg == '0)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = erm_pkg::ST_EMPTY;
                                out_popped_next = 1'b0;
                            end
                            else
                            begin
                                rd_en       = 1'b1;
                                rd_idx_next = advance(rd_idx_reg, cap_eff);
                                fill_next   = fill_reg - 1'b1;
                                state_next  = S_POP;
                            end
                        end
                        erm_pkg::REQ_FLUSH:
                        begin
                            wr_idx_next     = '0;
                            rd_idx_next     = '0;
                            fill_next       = '0;
                            out_valid_next  = 1'b1;
                            out_status_next = erm_pkg::ST_FLUSHED;
                            out_popped_next = 1'b0;
                        end
                        default:
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = erm_pkg::ST_IGNORED;
                            out_popped_next = 1'b0;
                        end
                    endcase
                end
            end
            S_MARK:
            begin
                // Second write of a marked push: the event only if a slot is left.
                if (!ring_full)
                begin
                    wr_en           = 1'b1;
                    wr_entry        = hold_reg;
                    wr_idx_next     = advance(wr_idx_reg, cap_eff);
                    fill_next       = fill_reg + 1'b1;
                    out_status_next = erm_pkg::ST_MARKED;
                end
                else
                begin
                    drop_cnt_next   = drop_cnt_reg + 1'b1;
                    out_status_next = erm_pkg::ST_DROPPED;
                end
                out_valid_next  = 1'b1;
                out_popped_next = 1'b0;
                state_next      = S_IDLE;
            end
            S_POP:
            begin
                // Read data of the oldest slot is now in the memory output register.
                out_valid_next  = 1'b1;
                out_status_next = erm_pkg::ST_OK;
                out_popped_next = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and ring state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            wr_idx_reg     <= '0;
            rd_idx_reg     <= '0;
            fill_reg       <= '0;
            last_seq_reg   <= '0;
            marker_reg     <= 1'b0;
            ev_cnt_reg     <= '0;
            drop_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= erm_pkg::ST_OK;
            out_popped_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wr_idx_reg     <= wr_idx_next;
            rd_idx_reg     <= rd_idx_next;
            fill_reg       <= fill_next;
            last_seq_reg   <= last_seq_next;
            marker_reg     <= marker_next;
            ev_cnt_reg     <= ev_cnt_next;
            drop_cnt_reg   <= drop_cnt_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_popped_reg <= out_popped_next;
        end
    end

    // Event held between the marker write and the event write.
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    // Slot memory: one write port, one registered read port. A pop is only accepted after
    // every earlier write has landed, so a read never meets a write to the same slot.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_idx_reg] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_idx_reg];
        end
    end

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_en_reg <= 1'b1;
            cap_reg    <= erm_pkg::CAP_RESET;
            ovf_op_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr)
                erm_pkg::CFG_TAP_ENABLED:     tap_en_reg <= cfg_data[0];
                erm_pkg::CFG_RING_CAPACITY:   cap_reg    <= cfg_data;
                erm_pkg::CFG_OVERFLOW_OPCODE: ovf_op_reg <= cfg_data[7:0];
                default:                      ;
            endcase
        end
    end

    // Result item. The ring state does not move while a result waits, so the fill level and
    // totals are taken straight from the state registers.
    assign pop_entry = out_popped_reg ? rd_data_reg : '0;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {5'd0, drop_cnt_reg, ev_cnt_reg, erm_pkg::QUEUED_W'(fill_reg),
                       pop_entry.seq, pop_entry.object_id, pop_entry.parent_id,
                       pop_entry.flags, pop_entry.cookie, pop_entry.op};

    // The fill level never passes the built depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(fill_reg) <= DEPTH_C)
        else $error("fill level beyond ring depth");

    // A pop of a non-empty ring always goes to the read-data state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == erm_pkg::REQ_POP && fill_reg != '0) |=> state_reg == S_POP)
        else $error("pop did not wait for read data");

    // No write while a read result is being collected.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |-> !wr_en)
        else $error("slot write during pop");

    // The sequence number moves by at most two per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (last_seq_reg - $past(last_seq_reg)) <= 64'd2)
        else $error("sequence number jumped");

    // A marked push always finishes with a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("marked push gave no result");

endmodule
